/* hw/rtl/htrp_pkg.sv */
// ----------------------------------------------------------------------------
// htrp_pkg
// Shared types and constants for the tree record packer: token kinds,
// packing limits and the job word that moves from front to back.
// ----------------------------------------------------------------------------
package htrp_pkg;

  // bits per packed byte
  localparam int BYTE_BITS = 8;

  // element bytes kept per leaf
  localparam int ELEM_BYTES = 4;

  // width of the leaf element field
  localparam int ELEM_BITS = 32;

  // most bytes one token can complete, and the bit span they cover
  localparam int MAX_BYTES = 6;
  localparam int JOB_BITS  = MAX_BYTES * BYTE_BITS;

  // widest token: marker bit, eight count bits, thirty-two element bits
  localparam int TOK_BITS = 1 + BYTE_BITS + ELEM_BITS;

  // largest byte count written for a leaf
  localparam int CNT_CAP = (ELEM_BYTES - 1 > 3) ? 3 : ELEM_BYTES - 1;

  // count field width after reset
  localparam logic [3:0] CFG_RESET = 4'd2;

  // default depth of the job queue
  localparam int QUEUE_DEPTH_DEF = 2;

  // token kinds
  typedef enum logic [1:0] {
    TOK_INTERNAL = 2'd0,
    TOK_LEAF     = 2'd1,
    TOK_NULL     = 2'd2,
    TOK_FLUSH    = 2'd3
  } tok_kind_t;

  // completed bytes of one token, first byte in the top bits
  typedef struct packed {
    logic [JOB_BITS-1:0] bits;
    logic [2:0]          nbytes;
  } job_t;

endpackage

/* hw/rtl/htrp_front.sv */
// ----------------------------------------------------------------------------
// htrp_front
// Accepts tokens, appends their bits to the partial byte and hands every
// run of completed bytes to the job queue; keeps the count field register.
// ----------------------------------------------------------------------------
module htrp_front (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 s_tvalid,
  output logic                 s_tready,
  input  logic [31:0]          s_tdata,   // element_value [31:0]
  input  logic [1:0]           s_tuser,   // req_type [1:0]
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [3:0]           cfg_data,
  input  logic                 q_full,
  output logic                 q_push,
  output htrp_pkg::job_t       q_job
);
  import htrp_pkg::*;

  logic [3:0]          count_field_bits;
  logic [7:0]          pending_bits;
  logic [2:0]          pending_count;
  logic [7:0]          pending_bits_next;
  logic [2:0]          pending_count_next;

  logic                accept;
  tok_kind_t           kind;
  logic [3:0]          width;
  logic [1:0]          cnt_raw;
  logic [1:0]          cnt;
  logic [1:0]          cnt_field;
  logic [5:0]          elen;
  logic [ELEM_BITS-1:0] elem_masked;
  logic [TOK_BITS-1:0] tok;
  logic [5:0]          tok_len;
  logic [JOB_BITS-1:0] acc;
  logic [5:0]          total;
  logic [JOB_BITS-1:0] aligned;
  logic [2:0]          nbytes;

  assign cfg_ready = 1'b1;
  assign s_tready  = !q_full;
  assign accept    = s_tvalid && s_tready;
  assign kind      = tok_kind_t'(s_tuser);

  // count field width, wide settings act as eight
  assign width = (count_field_bits > 4'd8) ? 4'd8 : count_field_bits;

  // significant element bytes minus one
  always_comb begin
    if (s_tdata[31:24] != 8'd0) begin
      cnt_raw = 2'd3;
    end else if (s_tdata[23:16] != 8'd0) begin
      cnt_raw = 2'd2;
    end else if (s_tdata[15:8] != 8'd0) begin
      cnt_raw = 2'd1;
    end else begin
      cnt_raw = 2'd0;
    end
    cnt = (cnt_raw > 2'(CNT_CAP)) ? 2'(CNT_CAP) : cnt_raw;
  end

  // count bits that fit in the field
  always_comb begin
    case (width)
      4'd0:    cnt_field = 2'd0;
      4'd1:    cnt_field = {1'b0, cnt[0]};
      default: cnt_field = cnt;
    endcase
  end

  // element bits kept for the leaf
  always_comb begin
    case (cnt)
      2'd0:    elem_masked = {24'd0, s_tdata[7:0]};
      2'd1:    elem_masked = {16'd0, s_tdata[15:0]};
      2'd2:    elem_masked = {8'd0, s_tdata[23:0]};
      default: elem_masked = s_tdata;
    endcase
    elen = 6'({cnt, 3'b000}) + 6'd8;
  end

  // token bits, right aligned, and their length
  always_comb begin
    case (kind)
      TOK_INTERNAL: begin
        tok     = '0;
        tok_len = 6'd1;
      end
      TOK_NULL: begin
        tok     = TOK_BITS'(1);
        tok_len = 6'd1;
      end
      TOK_LEAF: begin
        tok     = (TOK_BITS'(1) << (6'(width) + elen))
                | (TOK_BITS'(cnt_field) << elen)
                | TOK_BITS'(elem_masked);
        tok_len = 6'd1 + 6'(width) + elen;
      end
      default: begin
        tok     = '0;
        tok_len = 6'd0;
      end
    endcase
  end

  // pending bits followed by the token, then left aligned
  always_comb begin
    acc     = (JOB_BITS'(pending_bits) << tok_len) | JOB_BITS'(tok);
    total   = 6'(pending_count) + tok_len;
    aligned = acc << (6'(JOB_BITS) - total);
    if (kind == TOK_FLUSH) begin
      nbytes             = (pending_count != 3'd0) ? 3'd1 : 3'd0;
      pending_bits_next  = 8'd0;
      pending_count_next = 3'd0;
    end else begin
      nbytes             = total[5:3];
      pending_count_next = total[2:0];
      pending_bits_next  = acc[7:0] & ~(8'hff << total[2:0]);
    end
  end

  assign q_push       = accept && (nbytes != 3'd0);
  assign q_job.bits   = aligned;
  assign q_job.nbytes = nbytes;

  // partial byte and count field register
  always_ff @(posedge clk) begin
    if (rst) begin
      count_field_bits <= CFG_RESET;
      pending_bits     <= 8'd0;
      pending_count    <= 3'd0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        count_field_bits <= cfg_data;
      end
      if (accept) begin
        pending_bits  <= pending_bits_next;
        pending_count <= pending_count_next;
      end
    end
  end

endmodule

/* hw/rtl/htrp_queue.sv */
// ----------------------------------------------------------------------------
// htrp_queue
// Short job queue between front and back so that each side stalls on its
// own.
// ----------------------------------------------------------------------------
module htrp_queue #(
  parameter int DEPTH = htrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  htrp_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           empty,
  output htrp_pkg::job_t head
);
  import htrp_pkg::*;

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  job_t          slots [DEPTH];
  logic [PW-1:0] wr_ptr;
  logic [PW-1:0] rd_ptr;
  logic [CW-1:0] count;

  assign full  = (count == CW'(DEPTH));
  assign empty = (count == '0);
  assign head  = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

/* hw/rtl/htrp_back.sv */
// ----------------------------------------------------------------------------
// htrp_back
// Takes jobs from the queue and sends their bytes out one word per cycle
// while m_tready is high, marking the last byte that each token completes.
// ----------------------------------------------------------------------------
module htrp_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_empty,
  input  htrp_pkg::job_t q_head,
  output logic           q_pop,
  output logic           m_tvalid,
  input  logic           m_tready,
  output logic [7:0]     m_tdata,   // out_byte [7:0]
  output logic           m_tlast    // last_of_run
);
  import htrp_pkg::*;

  logic [JOB_BITS-1:0] cur_bits;
  logic [2:0]          left;
  logic                take;

  assign m_tvalid = (left != 3'd0);
  assign m_tdata  = cur_bits[JOB_BITS-1 -: BYTE_BITS];
  assign m_tlast  = (left == 3'd1);
  assign take     = m_tvalid && m_tready;
  assign q_pop    = !q_empty && ((left == 3'd0) || (left == 3'd1 && take));

  // current job shift register
  always_ff @(posedge clk) begin
    if (rst) begin
      left <= 3'd0;
    end else if (q_pop) begin
      left <= q_head.nbytes;
    end else if (take) begin
      left <= left - 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      cur_bits <= q_head.bits;
    end else if (take) begin
      cur_bits <= cur_bits << BYTE_BITS;
    end
  end

endmodule

/* hw/rtl/huffman_tree_record_packer.sv */
// ----------------------------------------------------------------------------
// huffman_tree_record_packer
// Packs a preorder stream of tree tokens MSB-first into bytes.
// Bytes of an accepted token pass the job queue and the output shift register.
// Throughput: one token per cycle in while the queue has room, one byte per
// cycle out while m_tready is high; a leaf completes up to six bytes.
// Reset: synchronous; clears the partial byte, the queue and the output,
// count field width returns to 2.
// ----------------------------------------------------------------------------
module huffman_tree_record_packer #(
  parameter int QUEUE_DEPTH = htrp_pkg::QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // element_value [31:0]
  input  logic [1:0]  s_tuser,   // req_type [1:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // out_byte [7:0]
  output logic        m_tlast,   // last_of_run
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [3:0]  cfg_data
);
  import htrp_pkg::*;

  logic q_full;
  logic q_empty;
  logic q_push;
  logic q_pop;
  job_t push_job;
  job_t head_job;

  // token intake and bit assembly
  htrp_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data),
    .q_full    (q_full),
    .q_push    (q_push),
    .q_job     (push_job)
  );

  // job queue
  htrp_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_job (push_job),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head     (head_job)
  );

  // byte output
  htrp_back u_back (
    .clk      (clk),
    .rst      (rst),
    .q_empty  (q_empty),
    .q_head   (head_job),
    .q_pop    (q_pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

endmodule

/* dv/huffman_tree_record_packer_test.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// huffman_tree_record_packer_test
// Self-checking bench for the tree record packer. A scoreboard class keeps
// its own copy of the partial byte and the count field width, and predicts
// the packed bytes of every accepted token. Stimulus is a directed set of
// corner cases followed by random token streams under several count field
// widths, with random gaps and stalls on both stream sides.
// ----------------------------------------------------------------------------
module huffman_tree_record_packer_test;
  import htrp_pkg::*;

  localparam int IDLE_PCT      = 38;
  localparam int SETTLE_CYCLES = 8;
  localparam int STALL_LIMIT   = 4000;
  localparam int RAND_PHASES   = 5;
  localparam int PHASE_TOKENS  = 18;

  // one predicted output word
  typedef struct {
    logic [7:0] out_byte;
    logic       last_of_run;
  } packed_byte_t;

  // predicts packed bytes and compares them against the output stream
  class record_byte_predictor;
    logic [7:0]   acc_bits;
    int unsigned  acc_count;
    logic [3:0]   field_width;
    packed_byte_t expected_bytes[$];
    packed_byte_t token_bytes[$];
    int unsigned  error_count;
    int unsigned  bytes_checked;

    function new();
      acc_bits      = '0;
      acc_count     = 0;
      field_width   = CFG_RESET;
      error_count   = 0;
      bytes_checked = 0;
    endfunction

    function void set_width(logic [3:0] w);
      field_width = w;
    endfunction

    // shift one bit into the partial byte, emit when full
    function void push_bit(logic b);
      packed_byte_t pb;
      acc_bits = {acc_bits[6:0], b};
      acc_count++;
      if (acc_count == BYTE_BITS) begin
        pb.out_byte    = acc_bits;
        pb.last_of_run = 1'b0;
        token_bytes.push_back(pb);
        acc_bits  = '0;
        acc_count = 0;
      end
    endfunction

    // significant bytes minus one, capped by the element size
    function int unsigned extra_bytes(logic [31:0] v);
      int unsigned c;
      c = 0;
      for (int k = 1; k < 4; k++) begin
        if ((v >> (8 * k)) != 0) c = k;
      end
      if (c > ELEM_BYTES - 1) c = ELEM_BYTES - 1;
      return c;
    endfunction

    // note an accepted token and queue the bytes it completes
    function void take_token(tok_kind_t kind, logic [31:0] value);
      int unsigned w;
      int unsigned cnt;
      packed_byte_t pb;
      token_bytes.delete();
      case (kind)
        TOK_INTERNAL: push_bit(1'b0);
        TOK_NULL:     push_bit(1'b1);
        TOK_LEAF: begin
          w   = (field_width > 8) ? 8 : field_width;
          cnt = extra_bytes(value);
          push_bit(1'b1);
          for (int i = int'(w) - 1; i >= 0; i--) push_bit(1'((cnt >> i) & 1));
          for (int i = int'((cnt + 1) * 8) - 1; i >= 0; i--) push_bit(value[i]);
        end
        default: begin
          // flush pads the partial byte with zeros
          if (acc_count != 0) begin
            pb.out_byte    = acc_bits << (BYTE_BITS - acc_count);
            pb.last_of_run = 1'b0;
            token_bytes.push_back(pb);
            acc_bits  = '0;
            acc_count = 0;
          end
        end
      endcase
      if (token_bytes.size() > 0) token_bytes[token_bytes.size() - 1].last_of_run = 1'b1;
      foreach (token_bytes[i]) expected_bytes.push_back(token_bytes[i]);
    endfunction

    // compare one accepted output word with the oldest prediction
    function void match_byte(logic [7:0] b, logic last);
      packed_byte_t pb;
      bytes_checked++;
      if (expected_bytes.size() == 0) begin
        $error("unexpected output word: out_byte %02h last_of_run %0b", b, last);
        error_count++;
        return;
      end
      pb = expected_bytes.pop_front();
      if (pb.out_byte !== b) begin
        $error("out_byte mismatch: expected %02h, actual %02h", pb.out_byte, b);
        error_count++;
      end
      if (pb.last_of_run !== last) begin
        $error("last_of_run mismatch: expected %0b, actual %0b", pb.last_of_run, last);
        error_count++;
      end
    endfunction
  endclass

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;   // element_value [31:0]
  logic [1:0]  s_tuser;   // req_type [1:0]
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;   // out_byte [7:0]
  logic        m_tlast;   // last_of_run
  logic        cfg_valid;
  logic        cfg_ready;
  logic [3:0]  cfg_data;

  record_byte_predictor sb = new();
  bit          no_idle;
  int unsigned tokens_sent;
  int unsigned widths_used;
  int unsigned stall_count;

  huffman_tree_record_packer DUT (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tlast   (m_tlast),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  // sink side back pressure
  initial begin
    m_tready <= 1'b0;
    forever begin
      @(posedge clk);
      m_tready <= no_idle ? 1'b1 : ($urandom_range(99) >= IDLE_PCT);
    end
  end

  // monitor: note accepted tokens first, then check accepted words
  always @(posedge clk) begin
    if (!rst) begin
      if (s_tvalid && s_tready) sb.take_token(tok_kind_t'(s_tuser), s_tdata);
      if (m_tvalid && m_tready) sb.match_byte(m_tdata, m_tlast);
    end
  end

  // watchdog on cycles without any handshake
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready)) begin
      stall_count <= 0;
    end else if (stall_count >= STALL_LIMIT) begin
      $display("Verification failed");
      $finish;
    end else begin
      stall_count <= stall_count + 1;
    end
  end

  // present one token, with a random gap before it, and wait for acceptance
  task automatic send_token(input tok_kind_t kind, input logic [31:0] value);
    while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= value;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    tokens_sent++;
  endtask

  // wait until every predicted word has come out and the block is quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (sb.expected_bytes.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // write the count field width while idle
  task automatic write_width(input logic [3:0] w);
    cfg_valid <= 1'b1;
    cfg_data  <= w;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    sb.set_width(w);
    widths_used++;
  endtask

  // leaf value with a random number of significant bytes
  function automatic logic [31:0] leaf_value();
    int unsigned nb;
    logic [31:0] v;
    nb = $urandom_range(4, 1);
    v  = $urandom;
    if (nb < 4) v = v & ((32'h1 << (8 * nb)) - 1);
    return v;
  endfunction

  // random token: leaves most often, other kinds carry junk data
  task automatic send_random_token();
    int unsigned pick;
    pick = $urandom_range(99);
    if (pick < 40) send_token(TOK_LEAF, leaf_value());
    else if (pick < 62) send_token(TOK_INTERNAL, $urandom);
    else if (pick < 84) send_token(TOK_NULL, $urandom);
    else send_token(TOK_FLUSH, $urandom);
  endtask

  initial begin
    logic [3:0] phase_width[RAND_PHASES];
    no_idle     = 1'b0;
    tokens_sent = 0;
    widths_used = 0;
    rst       <= 1'b1;
    s_tvalid  <= 1'b0;
    s_tdata   <= '0;
    s_tuser   <= TOK_INTERNAL;
    cfg_valid <= 1'b0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset width, flush with nothing pending, partial bytes
    send_token(TOK_FLUSH, 32'hFFFF_FFFF);
    send_token(TOK_INTERNAL, 32'h0);
    send_token(TOK_NULL, 32'hFFFF_FFFF);
    send_token(TOK_FLUSH, 32'h0);
    repeat (4) send_token(TOK_INTERNAL, 32'h0);
    repeat (4) send_token(TOK_NULL, 32'h0);
    send_token(TOK_LEAF, 32'h0000_0000);
    send_token(TOK_LEAF, 32'hFFFF_FFFF);
    send_token(TOK_LEAF, 32'h0000_0100);
    send_token(TOK_LEAF, 32'h00FF_0000);
    send_token(TOK_FLUSH, 32'h0);
    send_token(TOK_FLUSH, 32'h0);
    settle();

    // count field of zero
    write_width(4'd0);
    send_token(TOK_LEAF, 32'h0000_00A5);
    send_token(TOK_FLUSH, 32'h0);
    settle();

    // count wider than a one bit field
    write_width(4'd1);
    send_token(TOK_LEAF, 32'h8000_0001);
    send_token(TOK_FLUSH, 32'h0);
    settle();

    // field width beyond eight clamps to eight
    write_width(4'd15);
    send_token(TOK_LEAF, 32'h0001_0000);
    send_token(TOK_NULL, 32'h0);
    send_token(TOK_FLUSH, 32'h0);
    settle();

    // random phases, one of them without any idling
    phase_width[0] = 4'd8;
    phase_width[1] = 4'd1;
    phase_width[2] = 4'($urandom_range(15, 9));
    phase_width[3] = 4'($urandom_range(7, 2));
    phase_width[4] = 4'($urandom_range(15));
    for (int p = 0; p < RAND_PHASES; p++) begin
      write_width(phase_width[p]);
      no_idle = (p == 2);
      for (int n = 0; n < PHASE_TOKENS; n++) send_random_token();
      send_token(TOK_FLUSH, $urandom);
      settle();
      no_idle = 1'b0;
    end

    $display("run covered %0d tokens and %0d packed bytes over %0d width settings",
             tokens_sent, sb.bytes_checked, widths_used + 1);
    if (sb.error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
